// ===== hw/rtl/cms_pkg.sv =====
package cms_pkg;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [1:0]  row_index;
        logic [9:0]  column_index;
        logic [5:0]  key_bit_index;
        logic [63:0] seed_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] count_value;
        logic [1:0]  done_op;
    } t_out_item;

    localparam logic [0:0] CFG_COLUMNS = 1'd0;
    localparam logic [0:0] CFG_ROWS    = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_HASH,
        S_MOD,
        S_RD,
        S_WR,
        S_READ1,
        S_READ2,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture input item
        logic clr_start;  // reset sweep address
        logic clr_step;   // clear one counter entry, advance
        logic hash_start; // start hash of current row
        logic hash_step;  // fold one group of key bits
        logic mod_start;
        logic mod_step;
        logic rd;         // issue counter read
        logic wr;         // write incremented counter
        logic row_next;
        logic seed_wr;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic mod_last;
        logic row_last;
        logic rows_zero;
    } t_stat;

endpackage

// ===== hw/rtl/count_min_sketch_update.sv =====
// update: per row, a seed hash folded from the key, then a bit-serial modulo unit,
// then a counter read and write; load seed writes the seed memory, read fetches a counter
// clear counters sweeps the whole counter memory, one counter per cycle
// one item at a time; result strobe lasts one cycle, the receiver cannot stall
// after reset the counters are cleared by a sweep of all ROWS*COLUMNS counters, busy high
module count_min_sketch_update import cms_pkg::*; #(
    parameter int ROWS       = 4,
    parameter int COLUMNS    = 1024,
    parameter int KEY_BITS   = 64,
    parameter int HASH_BITS  = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [10:0] r_cols;
    logic [2:0]  r_rows;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 11'd1024;
            r_rows <= 3'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: r_cols <= i_cfg_data[10:0];
                CFG_ROWS:    r_rows <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    cms_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_op   (t_op'(i_item.op)),
        .i_stat (stat),
        .o_busy (busy),
        .o_cmd  (cmd)
    );

    cms_dp #(
        .ROWS(ROWS), .COLUMNS(COLUMNS), .KEY_BITS(KEY_BITS),
        .HASH_BITS(HASH_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_strobe(o_strobe),
        .o_item  (o_item)
    );
endmodule

// ===== hw/rtl/cms_ram.sv =====
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/cms_ctrl.sv =====
module cms_ctrl import cms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_op   i_op,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    t_op    r_op;
    logic   r_clr_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_op    <= OP_CLEAR;
        end else begin
            r_state <= n_state;
            if (i_start && r_state == S_IDLE) begin
                r_op <= i_op;
            end
        end
    end

    // the power-up sweep emits nothing; a clear item does
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_item <= 1'b0;
        end else if (r_state == S_IDLE && i_start) begin
            r_clr_item <= (i_op == OP_CLEAR);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_UPDATE: n_state = i_stat.rows_zero ? S_DONE : S_HASH;
                        OP_LOAD:   n_state = S_DONE;
                        OP_READ:   n_state = S_READ1;
                        OP_CLEAR:  n_state = S_CLR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLR:   if (i_stat.clr_last) n_state = (r_op == OP_CLEAR && r_clr_item) ?
                                                     S_DONE : S_IDLE;
            S_HASH:  if (i_stat.hash_last) n_state = S_MOD;
            S_MOD:   if (i_stat.mod_last) n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = i_stat.row_last ? S_DONE : S_HASH;
            S_READ1: n_state = S_READ2;
            S_READ2: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
                if (i_start) begin
                    o_cmd.clr_start  = (i_op == OP_CLEAR);
                    o_cmd.hash_start = (i_op == OP_UPDATE);
                    o_cmd.seed_wr    = (i_op == OP_LOAD);
                end
            end
            S_CLR:   o_cmd.clr_step = 1'b1;
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                o_cmd.mod_start = i_stat.hash_last;
            end
            S_MOD:   o_cmd.mod_step = 1'b1;
            S_RD:    o_cmd.rd = 1'b1;
            S_WR: begin
                o_cmd.wr         = 1'b1;
                o_cmd.row_next   = 1'b1;
                o_cmd.hash_start = !i_stat.row_last;
            end
            S_READ1: o_cmd.rd = 1'b1;
            // keep the read address so the data holds into the done cycle
            S_READ2: o_cmd.rd = 1'b1;
            S_DONE:  o_cmd.emit = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/cms_dp.sv =====
module cms_dp import cms_pkg::*; #(
    parameter int ROWS       = 4,
    parameter int COLUMNS    = 1024,
    parameter int KEY_BITS   = 64,
    parameter int HASH_BITS  = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic [10:0] i_cols,
    input  logic [2:0]  i_rows,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_strobe,
    output t_out_item   o_item
);
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW  = $clog2(COLUMNS);
    localparam int KW  = $clog2(KEY_BITS);
    localparam int CNW = CW + 1;
    localparam int MW  = (HASH_BITS > CNW) ? HASH_BITS : CNW;
    localparam int STEPS = 8;                       // key bits folded per cycle
    localparam int HCYC  = (KEY_BITS + STEPS - 1) / STEPS;
    localparam int HCW   = $clog2(HCYC + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    t_in_item r_in;
    logic [RW-1:0] r_row;
    logic [RW:0]   r_rows_eff;
    logic [CNW-1:0] r_cols_eff;

    // effective row and column counts
    logic [CNW-1:0] cols_eff;
    logic [RW:0]    rows_eff;
    always_comb begin
        if (i_cols == '0 || 32'(i_cols) > COLUMNS) cols_eff = CNW'(COLUMNS);
        else cols_eff = CNW'(i_cols);
        if (32'(i_rows) > ROWS) rows_eff = (RW+1)'(ROWS);
        else rows_eff = (RW+1)'(i_rows);
    end
    assign o_stat.rows_zero = (rows_eff == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in       <= i_item;
            r_cols_eff <= cols_eff;
            r_rows_eff <= rows_eff;
            r_row      <= '0;
        end else if (i_cmd.row_next) begin
            r_row <= r_row + 1'b1;
        end
    end
    assign o_stat.row_last = ((RW+1)'(r_row) + 1'b1 == r_rows_eff);

    // seed memory, banked by key bit within a fold step
    logic [HCW-1:0] r_hcnt;
    logic [HASH_BITS-1:0] r_hash;
    logic [HASH_BITS-1:0] seed_rd [STEPS];
    logic [KW-1:0] ld_bit;
    assign ld_bit = i_item.key_bit_index[KW-1:0];
    logic ld_ok;
    assign ld_ok = (32'(i_item.row_index) < ROWS) && (32'(i_item.key_bit_index) < KEY_BITS);

    // hash step issues reads for group r_hcnt; data arrives next cycle
    logic [HCW-1:0] r_hgrp;
    logic r_hvalid;
    for (genvar g = 0; g < STEPS; g++) begin : g_bank
        localparam int BD  = ROWS * HCYC;
        localparam int BAW = $clog2(BD + 1);
        logic [BAW-1:0] wa, ra;
        assign wa = BAW'(32'(i_item.row_index) * HCYC + 32'(ld_bit) / STEPS);
        assign ra = BAW'(32'(r_row) * HCYC + 32'(r_hcnt));
        cms_ram #(.WIDTH(HASH_BITS), .DEPTH(BD + 1)) u_seed (
            .i_clk  (i_clk),
            .i_we   (i_cmd.seed_wr && ld_ok && (32'(ld_bit) % STEPS == g)),
            .i_waddr(wa),
            .i_wdata(i_item.seed_word[HASH_BITS-1:0]),
            .i_raddr(ra),
            .o_rdata(seed_rd[g])
        );
    end

    // xor fold of seeds, STEPS key bits per cycle
    logic [HASH_BITS-1:0] fold;
    always_comb begin
        fold = r_hash;
        for (int g = 0; g < STEPS; g++) begin
            if (r_hvalid && (32'(r_hgrp) * STEPS + g < KEY_BITS) &&
                r_in.key[6'(32'(r_hgrp) * STEPS + g)]) begin
                fold = fold ^ seed_rd[g];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= 1'b0;
        end else if (i_cmd.hash_start) begin
            r_hcnt   <= '0;
            r_hash   <= '0;
            r_hvalid <= 1'b0;
        end else if (i_cmd.hash_step) begin
            r_hash   <= fold;
            r_hgrp   <= r_hcnt;
            r_hvalid <= (32'(r_hcnt) < HCYC);
            r_hcnt   <= r_hcnt + 1'b1;
        end
    end
    assign o_stat.hash_last = (32'(r_hcnt) == HCYC);

    // restoring modulo, one quotient bit per cycle
    localparam int MCW = $clog2(HASH_BITS + 1);
    logic [MW:0]       r_rem;
    logic [HASH_BITS-1:0] r_sh;
    logic [MCW-1:0]    r_mcnt;
    logic [MW:0]       rem_sh, rem_sub;
    assign rem_sh  = {r_rem[MW-1:0], r_sh[HASH_BITS-1]};
    assign rem_sub = rem_sh - (MW+1)'(r_cols_eff);
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_rem  <= '0;
            r_sh   <= fold;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= rem_sub[MW] ? rem_sh : rem_sub;
            r_sh   <= r_sh << 1;
            r_mcnt <= r_mcnt + 1'b1;
        end
    end
    assign o_stat.mod_last = (32'(r_mcnt) == HASH_BITS - 1);

    // counter memory with clear sweep
    localparam int AW = $clog2(ROWS * COLUMNS);
    logic [AW:0]   r_clr;
    logic          cwe;
    logic [AW-1:0] cwa, cra, upd_a;
    logic [COUNT_BITS-1:0] cwd, crd;
    logic [CW-1:0] col;
    assign col   = CW'(r_rem);
    assign upd_a = AW'(32'(r_row) * COLUMNS + 32'(col));
    assign o_stat.clr_last = (32'(r_clr) == ROWS * COLUMNS - 1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    always_comb begin
        cra = (i_cmd.rd && r_in.op == OP_READ) ?
              AW'(32'(r_in.row_index) * COLUMNS + 32'(r_in.column_index)) : upd_a;
        if (i_cmd.clr_step) begin
            cwe = 1'b1;
            cwa = r_clr[AW-1:0];
            cwd = '0;
        end else begin
            cwe = i_cmd.wr;
            cwa = upd_a;
            cwd = (crd == CMAX) ? crd : crd + 1'b1;
        end
    end
    cms_ram #(.WIDTH(COUNT_BITS), .DEPTH(ROWS * COLUMNS)) u_cnt (
        .i_clk  (i_clk),
        .i_we   (cwe),
        .i_waddr(cwa),
        .i_wdata(cwd),
        .i_raddr(cra),
        .o_rdata(crd)
    );

    // result
    logic rd_ok;
    assign rd_ok = (32'(r_in.row_index) < ROWS) && (32'(r_in.column_index) < COLUMNS);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_item.done_op     <= r_in.op;
            o_item.count_value <= (r_in.op == OP_READ && rd_ok) ? 32'(crd) : '0;
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import cms_pkg::*;

    localparam int ROWS       = 4;
    localparam int COLUMNS    = 1024;
    localparam int KEY_BITS   = 64;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_strobe;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    count_min_sketch_update u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the sketch state
    logic [63:0] seed_mem [ROWS*KEY_BITS];
    logic [31:0] count_mem [ROWS*COLUMNS];
    logic [10:0] cols_cfg;
    logic [2:0]  rows_cfg;

    t_out_item pending_results [$];
    bit        failed;
    int        send_idle_pct;
    int        stall_cycles;

    // directed row: typed result where it is obvious
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int eff_cols();
        if (cols_cfg == 0 || cols_cfg > COLUMNS) return COLUMNS;
        return int'(cols_cfg);
    endfunction

    function automatic int eff_rows();
        return (rows_cfg > ROWS) ? ROWS : int'(rows_cfg);
    endfunction

    function automatic int hashed_column(int row, logic [63:0] key);
        logic [63:0] h;
        h = '0;
        for (int b = 0; b < KEY_BITS; b++)
            if (key[b]) h ^= seed_mem[row*KEY_BITS + b];
        return int'(h % 64'(eff_cols()));
    endfunction

    // apply one item to the shadow state and return its result
    function automatic t_out_item sketch_predict(t_in_item it);
        t_out_item r;
        int        c;
        r.count_value = '0;
        r.done_op     = it.op;
        case (t_op'(it.op))
            OP_UPDATE: begin
                for (int row = 0; row < eff_rows(); row++) begin
                    c = row*COLUMNS + hashed_column(row, it.key);
                    if (count_mem[c] != 32'hFFFF_FFFF) count_mem[c] = count_mem[c] + 1;
                end
            end
            OP_LOAD: seed_mem[it.row_index*KEY_BITS + it.key_bit_index] = it.seed_word;
            OP_READ: r.count_value = count_mem[it.row_index*COLUMNS + it.column_index];
            OP_CLEAR: begin
                for (int i = 0; i < ROWS*COLUMNS; i++) count_mem[i] = '0;
            end
        endcase
        return r;
    endfunction

    // hand one item over; start stays high into the next item when no gap follows
    task automatic issue_item(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item r;
        int        gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        r = sketch_predict(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register write with the block idle
    task automatic write_reg(logic [0:0] idx, logic [63:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_COLUMNS) cols_cfg = val[10:0];
        else rows_cfg = val[2:0];
    endtask

    function automatic t_in_item make_item(t_op op);
        t_in_item it;
        it.op            = op;
        it.key           = rand64();
        it.row_index     = 2'($urandom());
        it.column_index  = 10'($urandom());
        it.key_bit_index = 6'($urandom());
        it.seed_word     = rand64();
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result count=%h op=%0d", $time,
                         o_item.count_value, o_item.done_op);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_item.count_value !== want.count_value) begin
                    $display("%0t: count_value expected %h actual %h", $time,
                             want.count_value, o_item.count_value);
                    failed = 1'b1;
                end
                if (o_item.done_op !== want.done_op) begin
                    $display("%0t: done_op expected %0d actual %0d", $time,
                             want.done_op, o_item.done_op);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_directed_row dir_rows [$];
        t_directed_row dr;
        t_in_item      it;
        t_out_item     zero_res;
        logic [63:0]   hot_keys [8];
        int            pick;
        int            phase_len;

        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        failed       = 1'b0;
        stall_cycles = 0;
        send_idle_pct = 0;
        cols_cfg     = 11'd1024;
        rows_cfg     = 3'd4;
        for (int i = 0; i < ROWS*KEY_BITS; i++) seed_mem[i] = '0;
        for (int i = 0; i < ROWS*COLUMNS; i++) count_mem[i] = '0;
        for (int i = 0; i < 8; i++) hot_keys[i] = rand64();
        zero_res = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every seed gets loaded before the first update, extremes included
        for (int i = 0; i < ROWS*KEY_BITS; i++) begin
            it = make_item(OP_LOAD);
            it.row_index     = 2'(i / KEY_BITS);
            it.key_bit_index = 6'(i % KEY_BITS);
            if (i % 37 == 0) it.seed_word = '1;
            else if (i % 41 == 0) it.seed_word = '0;
            issue_item(it, 1'b0, zero_res);
        end

        // directed table at reset configuration
        it = make_item(OP_READ); it.row_index = 2'd0; it.column_index = 10'd0;
        dr.item = it; dr.typed = 1'b1; dr.result = '{32'd0, OP_READ}; dir_rows.push_back(dr);
        it = make_item(OP_READ); it.row_index = 2'd3; it.column_index = 10'd1023;
        dr.item = it; dr.result = '{32'd0, OP_READ}; dir_rows.push_back(dr);
        it = make_item(OP_UPDATE); it.key = '0;
        dr.item = it; dr.result = '{32'd0, OP_UPDATE}; dir_rows.push_back(dr);
        it = make_item(OP_UPDATE); it.key = '1;
        dr.item = it; dr.result = '{32'd0, OP_UPDATE}; dir_rows.push_back(dr);
        it = make_item(OP_UPDATE); it.key = 64'h1;
        dr.item = it; dr.result = '{32'd0, OP_UPDATE}; dir_rows.push_back(dr);
        it = make_item(OP_UPDATE); it.key = 64'h8000_0000_0000_0000;
        dr.item = it; dir_rows.push_back(dr);
        it = make_item(OP_UPDATE); it.key = 64'h1;
        dr.item = it; dir_rows.push_back(dr);
        dr.typed = 1'b0;
        for (int row = 0; row < ROWS; row++) begin
            it = make_item(OP_READ); it.row_index = 2'(row);
            it.column_index = 10'(hashed_column(row, 64'h1));
            dr.item = it; dir_rows.push_back(dr);
            it.column_index = 10'(hashed_column(row, 64'h0));
            dr.item = it; dir_rows.push_back(dr);
        end
        it = make_item(OP_LOAD); it.row_index = 2'd3; it.key_bit_index = 6'd63;
        it.seed_word = '1;
        dr.item = it; dr.typed = 1'b1; dr.result = '{32'd0, OP_LOAD}; dir_rows.push_back(dr);
        it = make_item(OP_CLEAR);
        dr.item = it; dr.result = '{32'd0, OP_CLEAR}; dir_rows.push_back(dr);
        it = make_item(OP_READ); it.row_index = 2'd0;
        it.column_index = 10'(hashed_column(0, 64'h1));
        dr.item = it; dr.result = '{32'd0, OP_READ}; dir_rows.push_back(dr);

        foreach (dir_rows[i]) issue_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

        // pause until everything is back before the random part
        start <= 1'b0;
        @(posedge i_clk);
        wait_drained();

        phase_len = 105;
        for (int n = 0; n < 630; n++) begin
            if (n == 0)   send_idle_pct = 27;
            if (n == 210) send_idle_pct = 50;
            if (n == 420) send_idle_pct = 0;
            if (n % phase_len == 0) begin
                case ((n / phase_len) % 6)
                    0: begin write_reg(CFG_COLUMNS, 64'd1); write_reg(CFG_ROWS, 64'd1); end
                    1: begin write_reg(CFG_COLUMNS, 64'd0); write_reg(CFG_ROWS, 64'd0); end
                    2: begin write_reg(CFG_COLUMNS, 64'd7); write_reg(CFG_ROWS, 64'd3); end
                    3: begin write_reg(CFG_COLUMNS, '1); write_reg(CFG_ROWS, 64'd7); end
                    4: begin write_reg(CFG_COLUMNS, 64'd1024); write_reg(CFG_ROWS, 64'd4); end
                    default: begin
                        write_reg(CFG_COLUMNS, rand64());
                        write_reg(CFG_ROWS, rand64());
                    end
                endcase
            end
            pick = $urandom_range(199);
            if (pick < 2) begin
                it = make_item(OP_CLEAR);
            end else if (pick < 18) begin
                // reload a seed, extremes now and then
                it = make_item(OP_LOAD);
                if ($urandom_range(3) == 0) it.seed_word = $urandom_range(1) ? '1 : '0;
            end else if (pick < 70) begin
                it = make_item(OP_READ);
                if ($urandom_range(3) != 0)
                    it.column_index = 10'(hashed_column(it.row_index,
                                                        hot_keys[$urandom_range(7)]));
            end else begin
                it = make_item(OP_UPDATE);
                if ($urandom_range(2) != 0) it.key = hot_keys[$urandom_range(7)];
            end
            issue_item(it, 1'b0, zero_res);
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
